### design/tsp_pkg.sv
// Shared types and constants for the tag stream parser.
`default_nettype none
package tsp_pkg;

  localparam int COUNT_W = 7;
  localparam int OFFSET_OUT_W = 16;
  localparam int INDEX_W = 6;

  localparam logic [4:0] LOW5 = 5'h1F;
  localparam logic [COUNT_W-1:0] MAX_TAGS_RESET = 7'd64;

  localparam logic KIND_TAG = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int REG_MAX_TAGS = 0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic                    record_kind;
    logic [7:0]              tag_first;
    logic [7:0]              tag_second;
    logic                    two_byte_tag;
    logic [7:0]              value_length;
    logic [OFFSET_OUT_W-1:0] value_offset;
    logic [INDEX_W-1:0]      tag_index;
    logic [COUNT_W-1:0]      tag_total;
    logic                    cut_short;
    logic                    run_last;
  } record_t;

endpackage
`default_nettype wire

### design/tsp_parse_core.sv
// Parse state machine that turns each byte into zero, one or two records.
`default_nettype none
module tsp_parse_core #(
  parameter int TAG_LIMIT = 64,
  parameter int OFFSET_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [7:0]                    field_byte,
  input  wire logic                          field_end,
  input  wire logic [tsp_pkg::COUNT_W-1:0]   max_tags,
  output logic      [1:0]                    push_n,
  output tsp_pkg::record_t                   rec0,
  output tsp_pkg::record_t                   rec1
);

  localparam logic [1:0] PH_TAG1 = 2'd0;
  localparam logic [1:0] PH_TAG2 = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  localparam logic [tsp_pkg::COUNT_W-1:0] LIMIT_CAP = tsp_pkg::COUNT_W'(TAG_LIMIT);

  logic [1:0]                     parse_phase, parse_phase_next;
  logic [7:0]                     saved_tag_first, saved_tag_first_next;
  logic [7:0]                     saved_tag_second, saved_tag_second_next;
  logic                           saved_two_byte, saved_two_byte_next;
  logic [7:0]                     skip_remaining, skip_remaining_next;
  logic [OFFSET_BITS-1:0]         byte_position, byte_position_next;
  logic [tsp_pkg::COUNT_W-1:0]    records_found, records_found_next;

  logic [tsp_pkg::COUNT_W-1:0]    limit;
  logic [OFFSET_BITS-1:0]         pos_inc;
  logic [OFFSET_BITS+15:0]        pos_ext;
  logic [7:0]                     skip_dec;
  logic                           have_tag;
  tsp_pkg::record_t               tag_rec;
  tsp_pkg::record_t               sum_rec;

  assign limit   = (max_tags > LIMIT_CAP) ? LIMIT_CAP : max_tags;
  assign pos_inc = byte_position + 1'b1;
  assign pos_ext = {16'b0, pos_inc};
  assign skip_dec = (skip_remaining != 8'd0) ? skip_remaining - 8'd1 : skip_remaining;

  always_comb begin
    parse_phase_next      = parse_phase;
    saved_tag_first_next  = saved_tag_first;
    saved_tag_second_next = saved_tag_second;
    saved_two_byte_next   = saved_two_byte;
    skip_remaining_next   = skip_remaining;
    records_found_next    = records_found;
    byte_position_next    = pos_inc;
    have_tag              = 1'b0;
    tag_rec               = '0;
    sum_rec               = '0;

    case (parse_phase)
      PH_TAG1: begin
        if (records_found < limit) begin
          saved_tag_first_next  = field_byte;
          saved_tag_second_next = 8'd0;
          saved_two_byte_next   = (field_byte[4:0] == tsp_pkg::LOW5);
          parse_phase_next = (field_byte[4:0] == tsp_pkg::LOW5) ? PH_TAG2 : PH_LEN;
        end
      end
      PH_TAG2: begin
        saved_tag_second_next = field_byte;
        parse_phase_next      = PH_LEN;
      end
      PH_LEN: begin
        have_tag             = 1'b1;
        tag_rec.record_kind  = tsp_pkg::KIND_TAG;
        tag_rec.tag_first    = saved_tag_first;
        tag_rec.tag_second   = saved_tag_second;
        tag_rec.two_byte_tag = saved_two_byte;
        tag_rec.value_length = field_byte;
        tag_rec.value_offset = pos_ext[15:0];
        tag_rec.tag_index    = records_found[tsp_pkg::INDEX_W-1:0];
        records_found_next   = records_found + 1'b1;
        skip_remaining_next  = field_byte;
        parse_phase_next     = (field_byte == 8'd0) ? PH_TAG1 : PH_SKIP;
      end
      PH_SKIP: begin
        skip_remaining_next = skip_dec;
        if (skip_dec == 8'd0) begin
          parse_phase_next = PH_TAG1;
        end
      end
      default: begin
        parse_phase_next = PH_TAG1;
      end
    endcase

    sum_rec.record_kind = tsp_pkg::KIND_SUMMARY;
    sum_rec.tag_total   = records_found_next;
    sum_rec.cut_short   = (parse_phase_next != PH_TAG1);
    sum_rec.run_last    = 1'b1;

    if (have_tag) begin
      rec0          = tag_rec;
      rec0.run_last = !field_end;
      rec1          = sum_rec;
    end else begin
      rec0 = sum_rec;
      rec1 = '0;
    end
    push_n = {1'b0, have_tag} + {1'b0, field_end};

    if (field_end) begin
      parse_phase_next      = PH_TAG1;
      saved_tag_first_next  = 8'd0;
      saved_tag_second_next = 8'd0;
      saved_two_byte_next   = 1'b0;
      skip_remaining_next   = 8'd0;
      byte_position_next    = '0;
      records_found_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_TAG1;
      saved_tag_first  <= 8'd0;
      saved_tag_second <= 8'd0;
      saved_two_byte   <= 1'b0;
      skip_remaining   <= 8'd0;
      byte_position    <= '0;
      records_found    <= '0;
    end else if (accept) begin
      parse_phase      <= parse_phase_next;
      saved_tag_first  <= saved_tag_first_next;
      saved_tag_second <= saved_tag_second_next;
      saved_two_byte   <= saved_two_byte_next;
      skip_remaining   <= skip_remaining_next;
      byte_position    <= byte_position_next;
      records_found    <= records_found_next;
    end
  end

  a_restart_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && field_end) |=> (parse_phase == PH_TAG1 && records_found == '0
                               && byte_position == '0))
    else $error("Parser state not cleared after the final beat of a field.");

  a_records_capped: assert property (@(posedge clk) disable iff (rst)
    records_found <= LIMIT_CAP)
    else $error("Record count exceeds the tag limit.");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_SKIP) |-> (skip_remaining != 8'd0))
    else $error("Skip phase entered with nothing left to skip.");

endmodule
`default_nettype wire

### design/tsp_out_queue.sv
// Output queue that takes up to two records per cycle and delivers one per cycle while out_ready is high.
`default_nettype none
module tsp_out_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       push_n,
  input  wire tsp_pkg::record_t push0,
  input  wire tsp_pkg::record_t push1,
  output logic                  space,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tsp_pkg::record_t      head
);

  localparam logic [tsp_pkg::QCNT_W-1:0] ROOM =
    tsp_pkg::QCNT_W'(tsp_pkg::QUEUE_DEPTH - 2);

  tsp_pkg::record_t              entries [tsp_pkg::QUEUE_DEPTH];
  logic [tsp_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [tsp_pkg::QPTR_W-1:0]    wr_ptr_b;
  logic [tsp_pkg::QCNT_W-1:0]    count, count_next;
  logic                          pop;

  assign space     = (count <= ROOM);
  assign out_valid = (count != '0);
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_b  = wr_ptr + 1'b1;
  assign count_next = count + tsp_pkg::QCNT_W'(push_n) - tsp_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr_b] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tsp_pkg::QPTR_W'(push_n);
      rd_ptr <= rd_ptr + tsp_pkg::QPTR_W'(pop);
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= tsp_pkg::QCNT_W'(tsp_pkg::QUEUE_DEPTH))
    else $error("Output queue holds more records than its depth.");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> space)
    else $error("Records pushed into a queue without room for two.");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |=> out_valid)
    else $error("Pushed record not offered on the output.");

endmodule
`default_nettype wire

### design/tlv_tag_stream_parser_unit.sv
// Top level of the tag stream parser: register port, parse core and output queue.
//
//   Channel   Signals                        Beat carries
//   input     in_valid / in_ready            field_byte, field_end
//   output    out_valid / out_ready          one tag record or field summary
//   config    psel/penable/pwrite/paddr      max_tags at address 0
//
// One byte is accepted per cycle while in_ready is high; with the queue empty its first
// record is on the output in the next cycle.
// A length byte that also ends a field gives two records; the queue absorbs
// the extra one, so with out_ready held high the input never stalls.
// in_ready is high while the four-entry output queue has room for two records, so it
// drops once three records wait. Reset is synchronous; it empties the queue, restarts
// parsing and sets max_tags to 64.
`default_nettype none
module tlv_tag_stream_parser_unit #(
  parameter int TAG_LIMIT = 64,
  parameter int OFFSET_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  field_byte,
  input  wire logic        field_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             record_kind,
  output logic [7:0]       tag_first,
  output logic [7:0]       tag_second,
  output logic             two_byte_tag,
  output logic [7:0]       value_length,
  output logic [15:0]      value_offset,
  output logic [5:0]       tag_index,
  output logic [6:0]       tag_total,
  output logic             cut_short,
  output logic             run_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [tsp_pkg::COUNT_W-1:0] max_tags;
  logic                        reg_hit;
  logic                        accept;
  logic [1:0]                  push_n;
  tsp_pkg::record_t            rec0, rec1, head;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'(tsp_pkg::REG_MAX_TAGS));
  assign prdata  = reg_hit ? {25'b0, max_tags} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tags <= tsp_pkg::MAX_TAGS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_tags <= pwdata[tsp_pkg::COUNT_W-1:0];
    end
  end

  assign accept = in_valid && in_ready;

  tsp_parse_core #(
    .TAG_LIMIT   (TAG_LIMIT),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .field_byte (field_byte),
    .field_end  (field_end),
    .max_tags   (max_tags),
    .push_n     (push_n),
    .rec0       (rec0),
    .rec1       (rec1)
  );

  tsp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (accept ? push_n : 2'd0),
    .push0     (rec0),
    .push1     (rec1),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign record_kind  = head.record_kind;
  assign tag_first    = head.tag_first;
  assign tag_second   = head.tag_second;
  assign two_byte_tag = head.two_byte_tag;
  assign value_length = head.value_length;
  assign value_offset = head.value_offset;
  assign tag_index    = head.tag_index;
  assign tag_total    = head.tag_total;
  assign cut_short    = head.cut_short;
  assign run_last     = head.run_last;

endmodule
`default_nettype wire

### tb/tlv_tag_stream_parser_unit_tb.sv
// Self-checking testbench for the TLV tag stream parser with a scoreboard class.
module tlv_tag_stream_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAG_LIMIT = 64;
  localparam int OFFSET_BITS = 16;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 60;
  localparam logic [2:0] MAX_TAGS_ADDR = 3'(4 * tsp_pkg::REG_MAX_TAGS);

  localparam logic [1:0] WANT_TAG   = 2'd0;
  localparam logic [1:0] WANT_TAG2  = 2'd1;
  localparam logic [1:0] WANT_LEN   = 2'd2;
  localparam logic [1:0] SKIP_VALUE = 2'd3;

  typedef logic [7:0] octet_q_t[$];

  class tlv_scoreboard_t;
    logic [6:0] max_tags;
    logic [1:0] phase;
    logic [7:0] tag_a;
    logic [7:0] tag_b;
    logic two_byte;
    logic [7:0] skip_left;
    logic [OFFSET_BITS-1:0] position;
    logic [6:0] found;
    tsp_pkg::record_t expected_q[$];
    int mismatches;
    int records_seen;
    int summaries_seen;

    function new();
      max_tags = tsp_pkg::MAX_TAGS_RESET;
      mismatches = 0;
      records_seen = 0;
      summaries_seen = 0;
      restart_field();
    endfunction

    function void restart_field();
      phase = WANT_TAG;
      tag_a = '0;
      tag_b = '0;
      two_byte = 1'b0;
      skip_left = '0;
      position = '0;
      found = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      tsp_pkg::record_t tag_rec;
      tsp_pkg::record_t sum_rec;
      logic have_tag;
      logic [6:0] limit;
      limit = (max_tags > TAG_LIMIT) ? 7'(TAG_LIMIT) : max_tags;
      have_tag = 1'b0;
      tag_rec = '0;
      sum_rec = '0;
      case (phase)
        WANT_TAG: begin
          if (found < limit) begin
            tag_a = b;
            tag_b = '0;
            two_byte = (b[4:0] == tsp_pkg::LOW5);
            phase = two_byte ? WANT_TAG2 : WANT_LEN;
          end
        end
        WANT_TAG2: begin
          tag_b = b;
          phase = WANT_LEN;
        end
        WANT_LEN: begin
          tag_rec.record_kind = tsp_pkg::KIND_TAG;
          tag_rec.tag_first = tag_a;
          tag_rec.tag_second = tag_b;
          tag_rec.two_byte_tag = two_byte;
          tag_rec.value_length = b;
          tag_rec.value_offset = 16'(position + 1'b1);
          tag_rec.tag_index = found[5:0];
          have_tag = 1'b1;
          found = found + 1'b1;
          skip_left = b;
          phase = (b == 8'd0) ? WANT_TAG : SKIP_VALUE;
        end
        default: begin
          if (skip_left > 0) skip_left = skip_left - 1'b1;
          if (skip_left == 0) phase = WANT_TAG;
        end
      endcase
      position = position + 1'b1;
      if (have_tag) begin
        tag_rec.run_last = !last;
        expected_q.push_back(tag_rec);
      end
      if (last) begin
        sum_rec.record_kind = tsp_pkg::KIND_SUMMARY;
        sum_rec.tag_total = found;
        sum_rec.cut_short = (phase != WANT_TAG);
        sum_rec.run_last = 1'b1;
        expected_q.push_back(sum_rec);
        restart_field();
      end
    endfunction

    function string fmt(tsp_pkg::record_t r);
      return $sformatf({"kind=%0d tag=%02h/%02h two=%0d len=%0d off=%0d idx=%0d",
                        " total=%0d cut=%0d last=%0d"},
                       r.record_kind, r.tag_first, r.tag_second, r.two_byte_tag,
                       r.value_length, r.value_offset, r.tag_index, r.tag_total,
                       r.cut_short, r.run_last);
    endfunction

    function void check_record(tsp_pkg::record_t got);
      tsp_pkg::record_t want;
      records_seen++;
      if (got.record_kind == tsp_pkg::KIND_SUMMARY) summaries_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected record: %s", fmt(got));
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: record %0d mismatch", records_seen);
          $display("  expected: %s", fmt(want));
          $display("  actual:   %s", fmt(got));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] field_byte;
  logic field_end;
  logic out_valid;
  logic out_ready;
  logic record_kind;
  logic [7:0] tag_first;
  logic [7:0] tag_second;
  logic two_byte_tag;
  logic [7:0] value_length;
  logic [15:0] value_offset;
  logic [5:0] tag_index;
  logic [6:0] tag_total;
  logic cut_short;
  logic run_last;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  tlv_scoreboard_t sb = new();
  bit calm = 1'b0;
  int beats_sent = 0;
  int settings_done = 0;

  tlv_tag_stream_parser_unit #(
    .TAG_LIMIT(TAG_LIMIT),
    .OFFSET_BITS(OFFSET_BITS)
  ) DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin : watchdog
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 13);
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic last);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    field_byte <= b;
    field_end <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, last);
    beats_sent++;
  endtask

  task automatic send_field(input octet_q_t bytes);
    foreach (bytes[i]) send_beat(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic write_max_tags(input logic [6:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_TAGS_ADDR;
    pwdata <= ($urandom() & ~32'h7F) | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.max_tags = value;
    settings_done++;
  endtask

  function automatic octet_q_t build_field();
    octet_q_t f;
    int kind;
    int len;
    int keep;
    logic [7:0] t;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 12)) f.push_back(8'($urandom()));
      return f;
    end
    repeat ($urandom_range(1, 6)) begin
      t = 8'($urandom());
      if ($urandom_range(99) < 35) t[4:0] = tsp_pkg::LOW5;
      f.push_back(t);
      if (t[4:0] == tsp_pkg::LOW5) f.push_back(8'($urandom()));
      len = ($urandom_range(79) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
      f.push_back(8'(len));
      repeat (len) f.push_back(8'($urandom()));
    end
    if (kind < 25) begin
      keep = $urandom_range(1, f.size());
      while (f.size() > keep) void'(f.pop_back());
    end
    return f;
  endfunction

  initial begin : result_sink
    tsp_pkg::record_t got;
    int hold_left;
    int next_hold;
    hold_left = 0;
    next_hold = 40;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = '{record_kind, tag_first, tag_second, two_byte_tag, value_length,
                value_offset, tag_index, tag_total, cut_short, run_last};
        sb.check_record(got);
      end
      if (hold_left == 0 && in_valid && sb.records_seen >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold += 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !take_break();
      end
    end
  end

  initial begin : stimulus
    octet_q_t f;
    logic [6:0] plan[8];
    int random_beats;
    int target;
    int guard;
    rst <= 1'b1;
    in_valid <= 1'b0;
    field_byte <= '0;
    field_end <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed fields at the reset limit.
    f = {8'h5A, 8'h00, 8'hFF, 8'h00, 8'h02, 8'hAA, 8'hBB, 8'h1F, 8'hFF, 8'h01, 8'h33};
    send_field(f);
    f = {8'h1F};
    send_field(f);
    f = {8'h3F, 8'h12};
    send_field(f);
    f = {8'h01, 8'h00};
    send_field(f);
    f = {8'h02, 8'h05};
    send_field(f);
    f = {8'h03, 8'h04, 8'h11};
    send_field(f);
    f = {8'h00};
    send_field(f);

    // Limit of one: bytes after the first record are ignored.
    write_max_tags(7'd1);
    f = {8'h01, 8'h00, 8'h02, 8'h00, 8'h03};
    send_field(f);

    // Limit of zero: nothing is parsed.
    write_max_tags(7'd0);
    f = {8'h01, 8'h00};
    send_field(f);

    plan = '{7'd64, 7'd2, 7'd1, 7'd5, 7'd127, 7'($urandom_range(3, 63)), 7'd0, 7'd64};
    random_beats = 0;
    foreach (plan[p]) begin
      write_max_tags(plan[p]);
      calm = (p == 3);
      target = random_beats + ((plan[p] == 0) ? 15 : 55);
      while (random_beats < target) begin
        f = build_field();
        send_field(f);
        random_beats += f.size();
      end
    end
    calm = 1'b0;

    f = {8'h9F, 8'h7E, 8'h01, 8'hC3};
    send_field(f);

    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("ERROR: %0d expected records never arrived", sb.pending());
      sb.mismatches += sb.pending();
    end

    $display("Sent %0d byte beats (%0d in random fields) under %0d max_tags settings.",
             beats_sent, random_beats, settings_done);
    $display("Checked %0d records, %0d of them field summaries; %0d mismatches.",
             sb.records_seen, sb.summaries_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
